[rtl/core/assert_macros.svh]
// Assertion macros shared by the flanger and fuzz RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/flfz_pkg.sv]
// Shared types, constants and the sine table generator of the flanger and fuzz block.
`default_nettype none

package flfz_pkg;

  // Default geometry of the delay line and the sine table.
  localparam int unsigned DELAY_DEPTH_DEF = 256;
  localparam int unsigned SINE_BITS_DEF   = 10;

  // Quarter turn in Q30, used to build the sine table.
  localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;

  // Reciprocals of the Taylor term divisors (2i)(2i+1), scaled by 2^48 and rounded up.
  // The scaled product stays exact for every term that the series produces.
  localparam int unsigned TAYLOR_SHIFT = 48;
  localparam logic [63:0] TAYLOR_RECIP [1:6] = '{
    ((64'd1 << TAYLOR_SHIFT) + 64'd5)   / 64'd6,
    ((64'd1 << TAYLOR_SHIFT) + 64'd19)  / 64'd20,
    ((64'd1 << TAYLOR_SHIFT) + 64'd41)  / 64'd42,
    ((64'd1 << TAYLOR_SHIFT) + 64'd71)  / 64'd72,
    ((64'd1 << TAYLOR_SHIFT) + 64'd109) / 64'd110,
    ((64'd1 << TAYLOR_SHIFT) + 64'd155) / 64'd156
  };

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register values after reset.
  localparam logic [15:0] RST_DELAY_OFFSET = 16'd22579;
  localparam logic [15:0] RST_DELAY_DEPTH  = 16'd22579;
  localparam logic [31:0] RST_PHASE_STEP   = 32'd48696;
  localparam logic [12:0] RST_FUZZ_GAIN    = 13'd2560;
  localparam logic [15:0] RST_OUT_LEVEL    = 16'd32768;

  // Shared multiplier operand and product widths.
  localparam int unsigned MA_W = 26;
  localparam int unsigned MB_W = 17;
  localparam int unsigned P_W  = MA_W + MB_W;

  // Full scale of the fuzz clip, 1.0 in Q15.
  localparam logic [16:0] FULL_SCALE = 17'd32768;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_OFFSET = 3'd0,
    REG_DELAY_DEPTH  = 3'd1,
    REG_PHASE_STEP   = 3'd2,
    REG_FUZZ_GAIN    = 3'd3,
    REG_OUT_LEVEL    = 3'd4
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAU_MUL,
    ST_TAU_SUM,
    ST_RD_NEAR,
    ST_MUL_NEAR,
    ST_MUL_FAR,
    ST_SUM_ABS,
    ST_MUL_GAIN,
    ST_MUL_LEVEL,
    ST_FINISH
  } state_e;

  // Sine of (pi/2) * j / 2^(bits-2) in Q15, from a 13th order Taylor series in Q30.
  // Only evaluated at elaboration to fill the quarter-wave table.
  function automatic logic [14:0] quarter_sine(input int unsigned j, input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [127:0]       wide;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (64'(PI_HALF_Q30) * 64'(j)) >> (bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int i = 1; i <= 6; i++) begin
      // Next term divided by (2i)(2i+1) through its scaled reciprocal.
      wide = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[i]);
      term = 64'(wide >> TAYLOR_SHIFT);
      if ((i & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/flfz_if.sv]
// Valid/ready channel interfaces for the audio input and output samples.
`default_nettype none

// Input sample channel.
interface flfz_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface flfz_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[rtl/core/flanger_fuzz_effect_core.sv]
// Flanger followed by fuzz distortion, one audio sample in and one sample out.
//
// Usage:
//   in_i carries one signed Q1.15 sample per transfer; out_o carries the processed
//   nonnegative Q0.15 sample. Every input transfer yields exactly one output transfer.
//   The user writes registers via cfg_we_i/cfg_idx_i/cfg_data_i only while idle; unenforced.
// Sequencing:
//   A sample is worked through a ten-state sequencer around one shared 26x17 multiplier
//   (LFO depth, near tap, far tap, fuzz gain, output level) and the delay line memory,
//   which is read once for each interpolation tap. The result is registered when the
//   sequencer leaves its last state; a new sample is taken only once it is idle again.
// Reset:
//   The delay line needs no clearing pass: the history count decides which entries have
//   been written. Phase, write pointer, history count and registers return to defaults.
// Stall:
//   A result waiting in the output register does not block the next input transfer;
//   only if the next result is ready before the old one is taken does the sequencer
//   wait in its last state.
`default_nettype none
`include "assert_macros.svh"

module flanger_fuzz_effect_core #(
  parameter int unsigned DELAY_DEPTH_SAMPLES = flfz_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SINE_TABLE_BITS     = flfz_pkg::SINE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  flfz_in_if.sink                          in_i,
  flfz_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [flfz_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [flfz_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AW      = $clog2(DELAY_DEPTH_SAMPLES);
  localparam int unsigned HW      = AW + 1;
  localparam int unsigned QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned QAW     = SINE_TABLE_BITS - 1;
  localparam int unsigned TAU_MAX = (DELAY_DEPTH_SAMPLES - 2) * 256 + 255;
  localparam int unsigned TW      = (AW + 10 > 19) ? AW + 10 : 19;
  localparam int unsigned MA_W    = flfz_pkg::MA_W;
  localparam int unsigned MB_W    = flfz_pkg::MB_W;
  localparam int unsigned P_W     = flfz_pkg::P_W;

  localparam logic signed [TW-1:0] TAU_MIN_S = TW'(256);
  localparam logic signed [TW-1:0] TAU_MAX_S = TW'(TAU_MAX);
  localparam logic [AW:0]          DEPTH_EXT = (AW + 1)'(DELAY_DEPTH_SAMPLES);
  localparam logic [HW-1:0]        HIST_FULL = HW'(DELAY_DEPTH_SAMPLES);
  localparam logic [AW-1:0]        WP_LAST   = AW'(DELAY_DEPTH_SAMPLES - 1);

  // Quarter-wave sine table, filled at elaboration.
  typedef logic [14:0] qrom_t [QUARTER + 1];

  function automatic qrom_t build_qrom();
    qrom_t r;
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      r[k] = flfz_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam qrom_t QROM = build_qrom();

  // Configuration registers.
  logic [15:0] delay_offset_q;
  logic [15:0] delay_depth_q;
  logic [31:0] phase_step_q;
  logic [12:0] fuzz_gain_q;
  logic [15:0] out_level_q;

  // Control state.
  flfz_pkg::state_e state_q, state_d;
  logic [AW-1:0]    wp_q;
  logic [HW-1:0]    hist_q;
  logic [31:0]      phase_q;
  logic             out_valid_q;

  // Datapath registers.
  logic signed [15:0]     x_q;
  logic [AW-1:0]          d_q;
  logic [7:0]             f_q;
  logic                   near_en_q;
  logic                   far_en_q;
  logic signed [MA_W-1:0] acc_q;
  logic signed [P_W-1:0]  p_q;
  logic signed [15:0]     rdata_q;
  logic [14:0]            rom_q;
  logic                   neg_q;
  logic [14:0]            out_q;

  logic signed [15:0] line_mem [DELAY_DEPTH_SAMPLES];

  // Sequencer outputs.
  logic                   in_ready;
  logic                   in_fire;
  logic                   load_out;
  logic                   mul_en;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic [AW-1:0]          back;

  // Derived values.
  logic [SINE_TABLE_BITS-1:0] lfo_idx;
  logic [QAW-1:0]             rom_addr;
  logic signed [15:0]         sine;
  logic signed [P_W-1:0]      prod;
  logic signed [TW-1:0]       tau_raw;
  logic signed [TW-1:0]       tau_cl;
  logic [AW-1:0]              d_new;
  logic [7:0]                 f_new;
  logic [HW-1:0]              needed;
  logic                       use_new;
  logic [AW:0]                wp_ext;
  logic [AW:0]                back_ext;
  logic [AW:0]                rd_idx;
  logic [AW-1:0]              rd_addr;
  logic signed [MA_W-1:0]     v_sum;
  logic signed [MA_W-1:0]     v_abs;
  logic [16:0]                clip_a;

  assign in_fire = in_i.valid && in_ready;
  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.sample_out = out_q;

  // LFO table address: the quadrant picks a mirrored index and the sign.
  assign lfo_idx  = phase_q[31 -: SINE_TABLE_BITS];
  assign rom_addr = lfo_idx[SINE_TABLE_BITS-2] ?
                    (QAW'(QUARTER) - {1'b0, lfo_idx[SINE_TABLE_BITS-3:0]}) :
                    {1'b0, lfo_idx[SINE_TABLE_BITS-3:0]};
  assign sine = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  // Shared multiplier.
  assign prod = P_W'(ma) * P_W'(mb);

  // Fractional delay from the LFO product, clamped to the usable line.
  always_comb begin
    tau_raw = $signed(TW'(p_q >>> 15)) + $signed(TW'({1'b0, delay_offset_q}));
    if (tau_raw < TAU_MIN_S) begin
      tau_cl = TAU_MIN_S;
    end else if (tau_raw > TAU_MAX_S) begin
      tau_cl = TAU_MAX_S;
    end else begin
      tau_cl = tau_raw;
    end
    d_new   = tau_cl[AW+7:8];
    f_new   = tau_cl[7:0];
    needed  = {1'b0, d_new} + HW'(f_new != 8'd0);
    use_new = (hist_q >= needed);
  end

  // Circular read address of a tap that lies back samples behind the write pointer.
  always_comb begin
    wp_ext   = {1'b0, wp_q};
    back_ext = {1'b0, back};
    if (wp_ext >= back_ext) begin
      rd_idx = wp_ext - back_ext;
    end else begin
      rd_idx = wp_ext + DEPTH_EXT - back_ext;
    end
    rd_addr = rd_idx[AW-1:0];
  end

  // Flanged sum, its magnitude and the clipped fuzz amplitude.
  always_comb begin
    v_sum = acc_q + $signed(p_q[MA_W-1:0]);
    v_abs = v_sum[MA_W-1] ? -v_sum : v_sum;
    if (p_q[P_W-1:16] > (P_W - 16)'(flfz_pkg::FULL_SCALE)) begin
      clip_a = flfz_pkg::FULL_SCALE;
    end else begin
      clip_a = p_q[32:16];
    end
  end

  // Sequencer: next state and multiplier operand selection.
  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    load_out = 1'b0;
    mul_en   = 1'b0;
    ma       = '0;
    mb       = '0;
    back     = d_q;
    unique case (state_q)
      flfz_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = flfz_pkg::ST_TAU_MUL;
        end
      end
      flfz_pkg::ST_TAU_MUL: begin
        mul_en  = 1'b1;
        ma      = MA_W'(sine);
        mb      = $signed({1'b0, delay_depth_q});
        state_d = flfz_pkg::ST_TAU_SUM;
      end
      flfz_pkg::ST_TAU_SUM: begin
        state_d = flfz_pkg::ST_RD_NEAR;
      end
      flfz_pkg::ST_RD_NEAR: begin
        back    = d_q;
        state_d = flfz_pkg::ST_MUL_NEAR;
      end
      flfz_pkg::ST_MUL_NEAR: begin
        back    = AW'(d_q + 1'b1);
        mul_en  = 1'b1;
        ma      = near_en_q ? MA_W'(rdata_q) : '0;
        mb      = $signed(MB_W'(9'd256 - {1'b0, f_q}));
        state_d = flfz_pkg::ST_MUL_FAR;
      end
      flfz_pkg::ST_MUL_FAR: begin
        mul_en  = 1'b1;
        ma      = far_en_q ? MA_W'(rdata_q) : '0;
        mb      = $signed(MB_W'(f_q));
        state_d = flfz_pkg::ST_SUM_ABS;
      end
      flfz_pkg::ST_SUM_ABS: begin
        state_d = flfz_pkg::ST_MUL_GAIN;
      end
      flfz_pkg::ST_MUL_GAIN: begin
        mul_en  = 1'b1;
        ma      = acc_q;
        mb      = $signed(MB_W'(fuzz_gain_q));
        state_d = flfz_pkg::ST_MUL_LEVEL;
      end
      flfz_pkg::ST_MUL_LEVEL: begin
        mul_en  = 1'b1;
        ma      = $signed(MA_W'(clip_a));
        mb      = $signed({1'b0, out_level_q});
        state_d = flfz_pkg::ST_FINISH;
      end
      flfz_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = flfz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = flfz_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flfz_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers, masked to their widths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_offset_q <= flfz_pkg::RST_DELAY_OFFSET;
      delay_depth_q  <= flfz_pkg::RST_DELAY_DEPTH;
      phase_step_q   <= flfz_pkg::RST_PHASE_STEP;
      fuzz_gain_q    <= flfz_pkg::RST_FUZZ_GAIN;
      out_level_q    <= flfz_pkg::RST_OUT_LEVEL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flfz_pkg::REG_DELAY_OFFSET: delay_offset_q <= cfg_data_i[15:0];
        flfz_pkg::REG_DELAY_DEPTH:  delay_depth_q  <= cfg_data_i[15:0];
        flfz_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data_i[31:0];
        flfz_pkg::REG_FUZZ_GAIN:    fuzz_gain_q    <= cfg_data_i[12:0];
        flfz_pkg::REG_OUT_LEVEL:    out_level_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Per-sample bookkeeping and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      hist_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        wp_q    <= (wp_q == WP_LAST) ? '0 : AW'(wp_q + 1'b1);
        hist_q  <= (hist_q == HIST_FULL) ? hist_q : HW'(hist_q + 1'b1);
        phase_q <= phase_q + phase_step_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sine table read, registered.
  always_ff @(posedge clk_i) begin
    rom_q <= QROM[rom_addr];
    neg_q <= lfo_idx[SINE_TABLE_BITS-1];
  end

  // Delay line memory: the input sample is written on its transfer, taps are read later.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_mem[wp_q] <= in_i.sample_in;
    end
    rdata_q <= line_mem[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= prod;
    end
    if (in_fire) begin
      x_q <= in_i.sample_in;
    end
    if (state_q == flfz_pkg::ST_TAU_SUM) begin
      d_q       <= d_new;
      f_q       <= f_new;
      near_en_q <= use_new;
      far_en_q  <= use_new && (f_new != 8'd0);
    end
    if (state_q == flfz_pkg::ST_MUL_FAR) begin
      acc_q <= (MA_W'(x_q) <<< 8) + $signed(p_q[MA_W-1:0]);
    end
    if (state_q == flfz_pkg::ST_SUM_ABS) begin
      acc_q <= v_abs;
    end
    if (load_out) begin
      out_q <= p_q[30:16];
    end
  end

  // Checks on the sequencer and the delay bookkeeping.
  `ASSERT_SAME(a_tap_in_range, clk_i, rst_ni, state_q == flfz_pkg::ST_RD_NEAR, (d_q >= AW'(1)) && (32'(d_q) <= DELAY_DEPTH_SAMPLES - 2), "delay tap outside the line")
  `ASSERT_SAME(a_out_from_finish, clk_i, rst_ni, $rose(out_valid_q), $past(load_out), "result shown without a finished sample")
  `ASSERT_SAME(a_hist_step, clk_i, rst_ni, hist_q != $past(hist_q), $past(load_out) && (hist_q == HW'($past(hist_q) + 1'b1)), "history count moved without a finished sample")
  `ASSERT_SAME(a_phase_step, clk_i, rst_ni, phase_q != $past(phase_q), $past(load_out), "LFO phase moved without a finished sample")

endmodule

`default_nettype wire
